// ===== sv/tcq_pkg.sv =====
`default_nettype none
package tcq_pkg;

    localparam int DEPTH_DEF = 32;

    localparam int PATIENT_W = 16;
    localparam int DOCTOR_W  = 10;
    localparam int DAY_W     = 16;
    localparam int SLOT_W    = 7;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 6;

    localparam logic [STATUS_W-1:0] ST_PUSHED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PATIENT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DOCTOR  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_POPPED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd5;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef struct packed {
        logic [PATIENT_W-1:0] patient;
        logic [DOCTOR_W-1:0]  doctor;
        logic [DAY_W-1:0]     day;
        logic [SLOT_W-1:0]    slot;
        logic                 urgent;
    } entry_t;

    typedef struct packed {
        logic cmp_en;
        logic push_en;
        logic pop_en;
        logic urgent;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

endpackage
`default_nettype wire

// ===== sv/tcq_cell.sv =====
`default_nettype none
module tcq_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire tcq_pkg::cell_ctrl_t ctrl,
    input  wire tcq_pkg::entry_t new_entry,
    input  wire                  left_valid,
    input  wire tcq_pkg::entry_t left_entry,
    input  wire                  left_stop,
    input  wire                  right_valid,
    input  wire tcq_pkg::entry_t right_entry,
    output logic                 valid,
    output tcq_pkg::entry_t      entry,
    output logic                 stop,
    output logic                 pat_match,
    output logic                 doc_match
);
    import tcq_pkg::*;

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;
    logic   pat_match_reg, pat_match_next;
    logic   doc_match_reg, doc_match_next;
    logic   same_time;

    // insertion point: first cell past the urgent run (urgent) or past the held run
    assign stop = ctrl.urgent ? !(valid_reg && entry_reg.urgent) : !valid_reg;

    assign same_time = valid_reg && (entry_reg.day == new_entry.day)
                       && (entry_reg.slot == new_entry.slot);

    always_comb
    begin
        valid_next     = valid_reg;
        entry_next     = entry_reg;
        pat_match_next = pat_match_reg;
        doc_match_next = doc_match_reg;
        if (ctrl.cmp_en)
        begin
            pat_match_next = same_time && (entry_reg.patient == new_entry.patient);
            doc_match_next = same_time && (entry_reg.doctor == new_entry.doctor);
        end
        if (ctrl.pop_en)
        begin
            valid_next = right_valid;
            entry_next = right_entry;
        end
        else if (ctrl.push_en)
        begin
            if (left_stop)
            begin
                valid_next = left_valid;
                entry_next = left_entry;
            end
            else if (stop)
            begin
                valid_next = 1'b1;
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg     <= entry_next;
        pat_match_reg <= pat_match_next;
        doc_match_reg <= doc_match_next;
    end

    assign valid     = valid_reg;
    assign entry     = entry_reg;
    assign pat_match = pat_match_reg;
    assign doc_match = doc_match_reg;

endmodule
`default_nettype wire

// ===== sv/tcq_resolve.sv =====
`default_nettype none
module tcq_resolve #(
    parameter int DEPTH = tcq_pkg::DEPTH_DEF
) (
    input  wire [DEPTH-1:0] pat_match,
    input  wire [DEPTH-1:0] doc_match,
    output logic            any_conflict,
    output logic            pat_conflict
);
    import tcq_pkg::*;

    logic [DEPTH-1:0] conf;
    logic [DEPTH-1:0] first;

    // lowest set bit: the conflict nearest the head decides
    assign conf         = pat_match | doc_match;
    assign first        = conf & (~conf + {{(DEPTH-1){1'b0}}, 1'b1});
    assign any_conflict = |conf;
    assign pat_conflict = |(first & pat_match);

endmodule
`default_nettype wire

// ===== sv/two_class_queue_with_conflict_check_unit.sv =====
`default_nettype none
// Channel  Direction  Handshake         Payload
// in       in         in_valid/in_stall req_type patient_id doctor_id day_number
//                                       time_slot urgent
// out      out        out_valid/out_stall status head_valid head_patient head_doctor
//                                       head_day head_slot head_urgent entry_count
//
// Each request goes through accept, compare in every cell, then shift/commit.
// The compare result is registered in the cells before the commit stage.
// Reset clears the cell valid bits, the count and the control; no clearing pass.
// A finished result waits in the output register; the commit of the next request
// waits while it is stalled, and the head fields read the cell at the head.
module two_class_queue_with_conflict_check_unit #(
    parameter int DEPTH = tcq_pkg::DEPTH_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire                               req_type,
    input  wire  [tcq_pkg::PATIENT_W-1:0]     patient_id,
    input  wire  [tcq_pkg::DOCTOR_W-1:0]      doctor_id,
    input  wire  [tcq_pkg::DAY_W-1:0]         day_number,
    input  wire  [tcq_pkg::SLOT_W-1:0]        time_slot,
    input  wire                               urgent,
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic [tcq_pkg::STATUS_W-1:0]      status,
    output logic                              head_valid,
    output logic [tcq_pkg::PATIENT_W-1:0]     head_patient,
    output logic [tcq_pkg::DOCTOR_W-1:0]      head_doctor,
    output logic [tcq_pkg::DAY_W-1:0]         head_day,
    output logic [tcq_pkg::SLOT_W-1:0]        head_slot,
    output logic                              head_urgent,
    output logic [tcq_pkg::COUNT_W-1:0]       entry_count
);
    import tcq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    state_t            state_reg, state_next;
    logic              req_pop_reg;
    entry_t            req_entry_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    cell_ctrl_t        ctrl;
    logic              accept;
    logic              commit;
    logic              any_conflict;
    logic              pat_conflict;

    logic [DEPTH-1:0]  valid_vec;
    logic [DEPTH-1:0]  stop_vec;
    logic [DEPTH-1:0]  pat_vec;
    logic [DEPTH-1:0]  doc_vec;
    entry_t            cell_q [DEPTH];

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign commit   = (state_reg == S_UPD) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctrl.cmp_en    = (state_reg == S_CMP);
        ctrl.push_en   = 1'b0;
        ctrl.pop_en    = 1'b0;
        ctrl.urgent    = req_entry_reg.urgent;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    if (req_pop_reg == REQ_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            status_next = ST_POPPED;
                            ctrl.pop_en = 1'b1;
                            count_next  = count_reg - CW'(1);
                        end
                    end
                    else if (any_conflict)
                    begin
                        status_next = pat_conflict ? ST_PATIENT : ST_DOCTOR;
                    end
                    else if (valid_vec[DEPTH-1])
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next  = ST_PUSHED;
                        ctrl.push_en = 1'b1;
                        count_next   = count_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (accept)
        begin
            req_pop_reg           <= req_type;
            req_entry_reg.patient <= patient_id;
            req_entry_reg.doctor  <= doctor_id;
            req_entry_reg.day     <= day_number;
            req_entry_reg.slot    <= time_slot;
            req_entry_reg.urgent  <= urgent;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic   l_valid;
        entry_t l_entry;
        logic   l_stop;
        logic   r_valid;
        entry_t r_entry;

        if (i == 0)
        begin : g_first
            assign l_valid = 1'b0;
            assign l_entry = '0;
            assign l_stop  = 1'b0;
        end
        else
        begin : g_mid
            assign l_valid = valid_vec[i-1];
            assign l_entry = cell_q[i-1];
            assign l_stop  = stop_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_valid = 1'b0;
            assign r_entry = '0;
        end
        else
        begin : g_inner
            assign r_valid = valid_vec[i+1];
            assign r_entry = cell_q[i+1];
        end

        tcq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_entry   (req_entry_reg),
            .left_valid  (l_valid),
            .left_entry  (l_entry),
            .left_stop   (l_stop),
            .right_valid (r_valid),
            .right_entry (r_entry),
            .valid       (valid_vec[i]),
            .entry       (cell_q[i]),
            .stop        (stop_vec[i]),
            .pat_match   (pat_vec[i]),
            .doc_match   (doc_vec[i])
        );
    end

    tcq_resolve #(
        .DEPTH (DEPTH)
    ) u_resolve (
        .pat_match    (pat_vec),
        .doc_match    (doc_vec),
        .any_conflict (any_conflict),
        .pat_conflict (pat_conflict)
    );

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign head_valid   = valid_vec[0];
    assign head_patient = valid_vec[0] ? cell_q[0].patient : '0;
    assign head_doctor  = valid_vec[0] ? cell_q[0].doctor  : '0;
    assign head_day     = valid_vec[0] ? cell_q[0].day     : '0;
    assign head_slot    = valid_vec[0] ? cell_q[0].slot    : '0;
    assign head_urgent  = valid_vec[0] ? cell_q[0].urgent  : 1'b0;
    assign entry_count  = COUNT_W'(count_reg);

`ifndef SYNTH
    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("count does not match held cells");

    a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + {{(DEPTH-1){1'b0}}, 1'b1})) == '0)
        else $error("held cells not packed at the head");

    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_UPD))
        else $error("result raised outside commit");

    a_no_commit_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && out_valid_reg && out_stall) |=> $stable(valid_vec))
        else $error("cells changed while result pending");
`endif

endmodule
`default_nettype wire
